### rtl/core/dglcd_pkg.sv
// Package: shared types and command codes of the dual graphic LCD controller.
`timescale 1ns / 1ps
`default_nettype none

package dglcd_pkg;

   typedef enum logic [1:0] {
      MODE_CMD_WR  = 2'd0,
      MODE_DATA_WR = 2'd1,
      MODE_STAT_RD = 2'd2,
      MODE_DATA_RD = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   localparam logic [7:0] CMD_DISP_OFF  = 8'h3E;
   localparam logic [7:0] CMD_DISP_ON   = 8'h3F;
   localparam logic [7:0] CMD_COL_MASK  = 8'hC0;
   localparam logic [7:0] CMD_SET_COL   = 8'h40;
   localparam logic [7:0] CMD_PAGE_MASK = 8'hF8;
   localparam logic [7:0] CMD_SET_PAGE  = 8'hB8;
   localparam logic [7:0] CMD_LINE_MASK = 8'hC0;
   localparam logic [7:0] CMD_SET_LINE  = 8'hC0;

   localparam logic [7:0] STATUS_OFF    = 8'h20;

endpackage

`default_nettype wire

### rtl/core/dglcd_if.sv
// Interfaces: request and response channels of the dual graphic LCD controller.
`timescale 1ns / 1ps
`default_nettype none

interface dglcd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic       chip;
   logic [7:0] value;

   modport source (output valid, output mode, output chip, output value, input ready);
   modport sink   (input valid, input mode, input chip, input value, output ready);
endinterface

interface dglcd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;

   modport source (output valid, output read_data, input ready);
   modport sink   (input valid, input read_data, output ready);
endinterface

`default_nettype wire

### rtl/core/dual_graphic_lcd_controller.sv
// Dual graphic LCD controller: two column-driver chips sharing one display RAM.
//
// req_bus carries one bus access per transfer: mode (command write, data write,
// status read, data read), chip select and a command or data byte. rsp_bus
// returns one byte per access: status or data for reads, zero for writes.
// A response appears in the cycle after its request transfer and sits in an
// output register; a new request is taken while that register is empty or
// being drained, so the block sustains one access per cycle.
// Data reads return the chip's output latch and refill it from RAM; the RAM
// read is registered, and the refilled latch is forwarded to a read of the
// same chip in the following cycle.
// After reset the display RAM is cleared one entry a cycle, covering all
// 2**(1 + page bits + column bits) entries (1024 at the default sizes);
// req_bus.ready stays low during that pass. Pointers, latches and display
// flags reset at once.
// When rsp_bus stalls, the pending response holds and req_bus.ready drops
// until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module dual_graphic_lcd_controller #(
   parameter int COLUMNS = 64,
   parameter int PAGES   = 8,
   parameter int CHIPS   = 2
) (
   input  wire          clock,
   input  wire          reset,
   dglcd_req_if.sink    req_bus,
   dglcd_rsp_if.source  rsp_bus
);
   import dglcd_pkg::*;

   localparam int COL_W     = $clog2(COLUMNS);
   localparam int PG_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int CH_W      = 1;
   localparam int ADDR_W    = CH_W + PG_W + COL_W;
   localparam int RAM_DEPTH = 1 << ADDR_W;
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

   function automatic logic [COL_W-1:0] col_wrap(input logic [5:0] v);
      logic [6:0] r;
      r = {1'b0, v};
      for (int i = 0; i < 8; i++) begin
         if (r >= 7'(COLUMNS)) begin
            r = r - 7'(COLUMNS);
         end
      end
      return COL_W'(r);
   endfunction

   function automatic logic [PG_W-1:0] page_wrap(input logic [2:0] v);
      logic [3:0] r;
      r = {1'b0, v};
      for (int i = 0; i < 8; i++) begin
         if (r >= 4'(PAGES)) begin
            r = r - 4'(PAGES);
         end
      end
      return PG_W'(r);
   endfunction

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   logic              on_ff    [CHIPS];
   logic [5:0]        line_ff  [CHIPS];
   logic [PG_W-1:0]   page_ff  [CHIPS];
   logic [COL_W-1:0]  col_ff   [CHIPS];
   logic [7:0]        latch_ff [CHIPS];

   logic              pend_ff;
   logic [CH_W-1:0]   pend_chip_ff;

   logic [7:0]        ram [RAM_DEPTH];
   logic [7:0]        ram_q_ff;

   logic              rsp_valid_ff;
   logic [7:0]        rsp_data_ff, rsp_data_in;

   logic              req_ready;
   logic              acc;
   mode_type          mode;
   logic [7:0]        value;
   logic [CH_W-1:0]   sel;
   logic [ADDR_W-1:0] cur_addr;
   logic [7:0]        cur_latch;
   logic [COL_W-1:0]  col_next;

   assign req_ready     = (state_ff == ST_RUN) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = req_ready;
   assign acc           = req_bus.valid && req_ready;
   assign mode          = mode_type'(req_bus.mode);
   assign value         = req_bus.value;
   assign sel           = (CHIPS > 1) ? req_bus.chip : 1'b0;
   assign cur_addr      = {sel, page_ff[sel], col_ff[sel]};
   assign col_next      = (col_ff[sel] == COL_LAST) ? '0 : col_ff[sel] + 1'b1;

   // forward the refill still in flight from the previous data read
   assign cur_latch = (pend_ff && pend_chip_ff == sel) ? ram_q_ff : latch_ff[sel];

   always_comb begin
      case (mode)
         MODE_STAT_RD: rsp_data_in = on_ff[sel] ? 8'h00 : STATUS_OFF;
         MODE_DATA_RD: rsp_data_in = cur_latch;
         default:      rsp_data_in = 8'h00;
      endcase
   end

   // clearing pass sequencer
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: ;
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // display RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         ram[clr_addr_ff] <= 8'h00;
      end else if (acc && mode == MODE_DATA_WR) begin
         ram[cur_addr] <= value;
      end
      if (acc && mode == MODE_DATA_RD) begin
         ram_q_ff <= ram[cur_addr];
      end
   end

   // per-chip pointers, flags and output latches
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHIPS; i++) begin
            on_ff[i]    <= 1'b0;
            line_ff[i]  <= '0;
            page_ff[i]  <= '0;
            col_ff[i]   <= '0;
            latch_ff[i] <= '0;
         end
         pend_ff      <= 1'b0;
         pend_chip_ff <= '0;
      end else begin
         if (pend_ff) begin
            latch_ff[pend_chip_ff] <= ram_q_ff;
         end
         pend_ff      <= acc && mode == MODE_DATA_RD;
         pend_chip_ff <= sel;
         if (acc) begin
            case (mode)
               MODE_CMD_WR: begin
                  if (value == CMD_DISP_OFF) begin
                     on_ff[sel] <= 1'b0;
                  end else if (value == CMD_DISP_ON) begin
                     on_ff[sel] <= 1'b1;
                  end else if ((value & CMD_COL_MASK) == CMD_SET_COL) begin
                     col_ff[sel] <= col_wrap(value[5:0]);
                  end else if ((value & CMD_PAGE_MASK) == CMD_SET_PAGE) begin
                     page_ff[sel] <= page_wrap(value[2:0]);
                  end else if ((value & CMD_LINE_MASK) == CMD_SET_LINE) begin
                     line_ff[sel] <= value[5:0];
                  end
               end
               MODE_DATA_WR: col_ff[sel] <= col_next;
               MODE_DATA_RD: col_ff[sel] <= col_next;
               default: ;
            endcase
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (acc) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.read_data = rsp_data_ff;

   a_no_transfer_while_clearing: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready)
      else $error("request taken during RAM clearing pass");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, col_ff[0]} < (COL_W + 1)'(COLUMNS))
      else $error("column pointer beyond panel width");

   a_write_returns_zero: assert property (@(posedge clock) disable iff (reset)
      acc && (mode == MODE_CMD_WR || mode == MODE_DATA_WR)
      |=> rsp_valid_ff && rsp_data_ff == 8'h00)
      else $error("write access produced a nonzero response");

   a_refill_follows_read: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(acc && mode == MODE_DATA_RD))
      else $error("latch refill without a preceding data read");

   a_line_kept: assert property (@(posedge clock) disable iff (reset)
      !acc |=> $stable(line_ff[0]))
      else $error("start line changed without a command transfer");

endmodule

`default_nettype wire
